FILE: rtl/xyph_pkg.sv
// Package for the XY position hold controller.
// Shared types, register map, control word and sequencer codes.
// No dependencies.
package xyph_pkg;

   localparam int DATA_FRAC_BITS_DEF = 16;
   localparam int GAIN_FRAC_BITS_DEF = 12;

   localparam int DATA_W   = 32;
   localparam int GAIN_W   = 16;
   localparam int LIMIT_W  = 31;
   localparam int PROD_W   = DATA_W + GAIN_W;
   localparam int ACC_W    = PROD_W + 1;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_POS_GAIN_X   = 3'd0,
      REG_POS_GAIN_Y   = 3'd1,
      REG_ROLL_P_GAIN  = 3'd2,
      REG_ROLL_D_GAIN  = 3'd3,
      REG_PITCH_GAIN   = 3'd4,
      REG_SPEED_LIMIT  = 3'd5,
      REG_ROLL_LIMIT   = 3'd6,
      REG_PITCH_LIMIT  = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] pos_gain_x;
      logic signed [GAIN_W-1:0] pos_gain_y;
      logic signed [GAIN_W-1:0] roll_p_gain;
      logic signed [GAIN_W-1:0] roll_d_gain;
      logic signed [GAIN_W-1:0] pitch_gain;
      logic [LIMIT_W-1:0]       speed_limit;
      logic [LIMIT_W-1:0]       roll_limit;
      logic [LIMIT_W-1:0]       pitch_limit;
   } cfg_type;

   typedef enum logic [2:0] {
      MSEL_PX,
      MSEL_PY,
      MSEL_PE,
      MSEL_DX,
      MSEL_EY
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef enum logic [1:0] {
      LIM_SPEED,
      LIM_ROLL,
      LIM_PITCH
   } lim_sel_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        clp_en;
      lim_sel_type lim_sel;
      logic        ex_en;
      logic        ey_en;
      logic        dx_en;
      logic        roll_en;
      logic        pitch_en;
   } ctrl_type;

endpackage

FILE: rtl/xyph_if.sv
// Item channel interfaces for the XY position hold controller.
// Depends on xyph_pkg.
interface xyph_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [xyph_pkg::DATA_W-1:0] pos_x;
   logic signed [xyph_pkg::DATA_W-1:0] pos_y;
   logic signed [xyph_pkg::DATA_W-1:0] speed_x;
   logic signed [xyph_pkg::DATA_W-1:0] speed_y;

   modport source (output valid, output pos_x, output pos_y, output speed_x,
                   output speed_y, input ready);
   modport sink (input valid, input pos_x, input pos_y, input speed_x,
                 input speed_y, output ready);
endinterface

interface xyph_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [xyph_pkg::DATA_W-1:0] roll_cmd;
   logic signed [xyph_pkg::DATA_W-1:0] pitch_cmd;

   modport source (output valid, output roll_cmd, output pitch_cmd,
                   input ready);
   modport sink (input valid, input roll_cmd, input pitch_cmd,
                 output ready);
endinterface

FILE: rtl/xyph_csr.sv
// Configuration register file (APB-style) for the XY position hold controller.
// Depends on xyph_pkg.
module xyph_csr #(
   parameter int DATA_FRAC_BITS = xyph_pkg::DATA_FRAC_BITS_DEF,
   parameter int GAIN_FRAC_BITS = xyph_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [xyph_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [xyph_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [xyph_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output xyph_pkg::cfg_type                 cfg
);

   localparam longint GainOne  = longint'(1) << GAIN_FRAC_BITS;
   localparam longint DataOne  = longint'(1) << DATA_FRAC_BITS;
   localparam longint GxRaw    = (64 * GainOne + 500) / 1000;
   localparam longint GyRaw    = (121 * GainOne + 500) / 1000;
   localparam longint RpRaw    = (14 * GainOne + 5) / 10;
   localparam longint RdRaw    = (22 * GainOne + 5) / 10;
   localparam longint GMax     = 32767;
   localparam longint GxSat    = (GxRaw > GMax) ? GMax : GxRaw;
   localparam longint GySat    = (GyRaw > GMax) ? GMax : GyRaw;
   localparam longint RpSat    = (RpRaw > GMax) ? GMax : RpRaw;
   localparam longint RdSat    = (RdRaw > GMax) ? GMax : RdRaw;
   localparam longint PgRst    = -GainOne;

   localparam logic [xyph_pkg::GAIN_W-1:0]  RstGx = xyph_pkg::GAIN_W'(GxSat);
   localparam logic [xyph_pkg::GAIN_W-1:0]  RstGy = xyph_pkg::GAIN_W'(GySat);
   localparam logic [xyph_pkg::GAIN_W-1:0]  RstRp = xyph_pkg::GAIN_W'(RpSat);
   localparam logic [xyph_pkg::GAIN_W-1:0]  RstRd = xyph_pkg::GAIN_W'(RdSat);
   localparam logic [xyph_pkg::GAIN_W-1:0]  RstPg = xyph_pkg::GAIN_W'(PgRst);
   localparam logic [xyph_pkg::LIMIT_W-1:0] RstSl = xyph_pkg::LIMIT_W'(5 * DataOne);
   localparam logic [xyph_pkg::LIMIT_W-1:0] RstRl = xyph_pkg::LIMIT_W'(6 * DataOne);
   localparam logic [xyph_pkg::LIMIT_W-1:0] RstPl = xyph_pkg::LIMIT_W'(5 * DataOne);

   xyph_pkg::cfg_type     cfg_ff, cfg_in;
   xyph_pkg::reg_idx_type idx;
   logic                  wr_en;

   assign idx        = xyph_pkg::reg_idx_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            xyph_pkg::REG_POS_GAIN_X:  cfg_in.pos_gain_x  = csr_pwdata[15:0];
            xyph_pkg::REG_POS_GAIN_Y:  cfg_in.pos_gain_y  = csr_pwdata[15:0];
            xyph_pkg::REG_ROLL_P_GAIN: cfg_in.roll_p_gain = csr_pwdata[15:0];
            xyph_pkg::REG_ROLL_D_GAIN: cfg_in.roll_d_gain = csr_pwdata[15:0];
            xyph_pkg::REG_PITCH_GAIN:  cfg_in.pitch_gain  = csr_pwdata[15:0];
            xyph_pkg::REG_SPEED_LIMIT: cfg_in.speed_limit = csr_pwdata[30:0];
            xyph_pkg::REG_ROLL_LIMIT:  cfg_in.roll_limit  = csr_pwdata[30:0];
            xyph_pkg::REG_PITCH_LIMIT: cfg_in.pitch_limit = csr_pwdata[30:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         xyph_pkg::REG_POS_GAIN_X:  csr_prdata = 32'(cfg_ff.pos_gain_x);
         xyph_pkg::REG_POS_GAIN_Y:  csr_prdata = 32'(cfg_ff.pos_gain_y);
         xyph_pkg::REG_ROLL_P_GAIN: csr_prdata = 32'(cfg_ff.roll_p_gain);
         xyph_pkg::REG_ROLL_D_GAIN: csr_prdata = 32'(cfg_ff.roll_d_gain);
         xyph_pkg::REG_PITCH_GAIN:  csr_prdata = 32'(cfg_ff.pitch_gain);
         xyph_pkg::REG_SPEED_LIMIT: csr_prdata = {1'b0, cfg_ff.speed_limit};
         xyph_pkg::REG_ROLL_LIMIT:  csr_prdata = {1'b0, cfg_ff.roll_limit};
         xyph_pkg::REG_PITCH_LIMIT: csr_prdata = {1'b0, cfg_ff.pitch_limit};
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pos_gain_x  <= RstGx;
         cfg_ff.pos_gain_y  <= RstGy;
         cfg_ff.roll_p_gain <= RstRp;
         cfg_ff.roll_d_gain <= RstRd;
         cfg_ff.pitch_gain  <= RstPg;
         cfg_ff.speed_limit <= RstSl;
         cfg_ff.roll_limit  <= RstRl;
         cfg_ff.pitch_limit <= RstPl;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/xyph_alu.sv
// Shared multiply/accumulate, round-clamp and saturating subtract datapath.
// Holds the sample, the intermediate errors, prev X error and result registers.
// Depends on xyph_pkg.
module xyph_alu #(
   parameter int GAIN_FRAC_BITS = xyph_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  xyph_pkg::ctrl_type                  ctrl,
   input  xyph_pkg::cfg_type                   cfg,
   input  logic signed [xyph_pkg::DATA_W-1:0]  pos_x,
   input  logic signed [xyph_pkg::DATA_W-1:0]  pos_y,
   input  logic signed [xyph_pkg::DATA_W-1:0]  speed_x,
   input  logic signed [xyph_pkg::DATA_W-1:0]  speed_y,
   output logic signed [xyph_pkg::DATA_W-1:0]  roll_cmd,
   output logic signed [xyph_pkg::DATA_W-1:0]  pitch_cmd
);

   localparam int DW = xyph_pkg::DATA_W;
   localparam int RW = xyph_pkg::ACC_W + 1;

   function automatic logic signed [DW-1:0] neg_sat(input logic signed [DW-1:0] x);
      logic signed [DW-1:0] r;
      if (x == {1'b1, {(DW-1){1'b0}}}) r = {1'b0, {(DW-1){1'b1}}};
      else                            r = -x;
      return r;
   endfunction

   function automatic logic signed [DW-1:0] sub_sat(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
      logic signed [DW:0]   d;
      logic signed [DW-1:0] r;
      d = {a[DW-1], a} - {b[DW-1], b};
      if (d[DW] != d[DW-1]) r = d[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      else                  r = d[DW-1:0];
      return r;
   endfunction

   logic signed [DW-1:0] px_ff, py_ff, vx_ff, vy_ff;
   logic signed [DW-1:0] ex_ff, ey_ff, dx_ff, prev_ff, clp_ff;
   logic signed [DW-1:0] roll_ff, pitch_ff;
   logic signed [xyph_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [xyph_pkg::ACC_W-1:0]  acc_ff, acc_in, prod_ext;
   logic signed [DW-1:0]               mul_a;
   logic signed [xyph_pkg::GAIN_W-1:0] mul_b;
   logic signed [RW-1:0]               rnd_sum, rnd_shift, lim_pos, lim_neg;
   logic [xyph_pkg::LIMIT_W-1:0]       lim;
   logic signed [DW-1:0]               clp_in;

   always_comb begin
      case (ctrl.mul_sel)
         xyph_pkg::MSEL_PX: begin mul_a = neg_sat(px_ff); mul_b = cfg.pos_gain_x; end
         xyph_pkg::MSEL_PY: begin mul_a = neg_sat(py_ff); mul_b = cfg.pos_gain_y; end
         xyph_pkg::MSEL_PE: begin mul_a = ex_ff; mul_b = cfg.roll_p_gain; end
         xyph_pkg::MSEL_DX: begin mul_a = dx_ff; mul_b = cfg.roll_d_gain; end
         xyph_pkg::MSEL_EY: begin mul_a = ey_ff; mul_b = cfg.pitch_gain; end
         default:           begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign prod_in  = mul_a * mul_b;
   assign prod_ext = {prod_ff[xyph_pkg::PROD_W-1], prod_ff};

   always_comb begin
      case (ctrl.acc_op)
         xyph_pkg::ACC_LOAD: acc_in = prod_ext;
         xyph_pkg::ACC_ADD:  acc_in = acc_ff + prod_ext;
         default:            acc_in = acc_ff;
      endcase
   end

   always_comb begin
      case (ctrl.lim_sel)
         xyph_pkg::LIM_SPEED: lim = cfg.speed_limit;
         xyph_pkg::LIM_ROLL:  lim = cfg.roll_limit;
         xyph_pkg::LIM_PITCH: lim = cfg.pitch_limit;
         default:             lim = '0;
      endcase
   end

   // round half up, floor shift, symmetric clamp
   always_comb begin
      rnd_sum   = {acc_ff[xyph_pkg::ACC_W-1], acc_ff}
                  + (RW'(1) <<< (GAIN_FRAC_BITS - 1));
      rnd_shift = rnd_sum >>> GAIN_FRAC_BITS;
      lim_pos   = $signed({{(RW-xyph_pkg::LIMIT_W){1'b0}}, lim});
      lim_neg   = -lim_pos;
      if (rnd_shift > lim_pos)      clp_in = lim_pos[DW-1:0];
      else if (rnd_shift < lim_neg) clp_in = lim_neg[DW-1:0];
      else                          clp_in = rnd_shift[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         px_ff <= pos_x;
         py_ff <= pos_y;
         vx_ff <= speed_x;
         vy_ff <= speed_y;
      end
      if (ctrl.mul_en)   prod_ff  <= prod_in;
      acc_ff <= acc_in;
      if (ctrl.clp_en)   clp_ff   <= clp_in;
      if (ctrl.ex_en)    ex_ff    <= sub_sat(clp_ff, vx_ff);
      if (ctrl.ey_en)    ey_ff    <= sub_sat(clp_ff, vy_ff);
      if (ctrl.dx_en)    dx_ff    <= sub_sat(ex_ff, prev_ff);
      if (ctrl.roll_en)  roll_ff  <= clp_ff;
      if (ctrl.pitch_en) pitch_ff <= clp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else if (ctrl.dx_en) begin
         prev_ff <= ex_ff;
      end
   end

   assign roll_cmd  = roll_ff;
   assign pitch_cmd = pitch_ff;

endmodule

FILE: rtl/xyph_seq.sv
// Sequencer for the XY position hold controller: one-hot state machine that
// steps the shared datapath and owns the item handshakes. Depends on xyph_pkg.
module xyph_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output xyph_pkg::ctrl_type ctrl
);

   typedef enum logic [11:0] {
      ST_IDLE = 12'b000000000001,
      ST_MX   = 12'b000000000010,
      ST_MY   = 12'b000000000100,
      ST_TX   = 12'b000000001000,
      ST_TY   = 12'b000000010000,
      ST_EY   = 12'b000000100000,
      ST_MP   = 12'b000001000000,
      ST_MD   = 12'b000010000000,
      ST_MG   = 12'b000100000000,
      ST_RL   = 12'b001000000000,
      ST_PT   = 12'b010000000000,
      ST_OUT  = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;
   logic      out_free;

   assign out_free  = ~valid_ff | rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in      = state_ff;
      ctrl.load     = 1'b0;
      ctrl.mul_en   = 1'b0;
      ctrl.mul_sel  = xyph_pkg::MSEL_PX;
      ctrl.acc_op   = xyph_pkg::ACC_HOLD;
      ctrl.clp_en   = 1'b0;
      ctrl.lim_sel  = xyph_pkg::LIM_SPEED;
      ctrl.ex_en    = 1'b0;
      ctrl.ey_en    = 1'b0;
      ctrl.dx_en    = 1'b0;
      ctrl.roll_en  = 1'b0;
      ctrl.pitch_en = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl.load = 1'b1;
               state_in  = ST_MX;
            end
         end
         ST_MX: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = xyph_pkg::MSEL_PX;
            state_in     = ST_MY;
         end
         ST_MY: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = xyph_pkg::MSEL_PY;
            ctrl.acc_op  = xyph_pkg::ACC_LOAD;
            state_in     = ST_TX;
         end
         ST_TX: begin
            ctrl.clp_en  = 1'b1;
            ctrl.lim_sel = xyph_pkg::LIM_SPEED;
            ctrl.acc_op  = xyph_pkg::ACC_LOAD;
            state_in     = ST_TY;
         end
         ST_TY: begin
            ctrl.ex_en   = 1'b1;
            ctrl.clp_en  = 1'b1;
            ctrl.lim_sel = xyph_pkg::LIM_SPEED;
            state_in     = ST_EY;
         end
         ST_EY: begin
            ctrl.ey_en = 1'b1;
            ctrl.dx_en = 1'b1;
            state_in   = ST_MP;
         end
         ST_MP: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = xyph_pkg::MSEL_PE;
            state_in     = ST_MD;
         end
         ST_MD: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = xyph_pkg::MSEL_DX;
            ctrl.acc_op  = xyph_pkg::ACC_LOAD;
            state_in     = ST_MG;
         end
         ST_MG: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = xyph_pkg::MSEL_EY;
            ctrl.acc_op  = xyph_pkg::ACC_ADD;
            state_in     = ST_RL;
         end
         ST_RL: begin
            // hold here until the result register is free
            if (out_free) begin
               ctrl.clp_en  = 1'b1;
               ctrl.lim_sel = xyph_pkg::LIM_ROLL;
               ctrl.acc_op  = xyph_pkg::ACC_LOAD;
               state_in     = ST_PT;
            end
         end
         ST_PT: begin
            ctrl.roll_en = 1'b1;
            ctrl.clp_en  = 1'b1;
            ctrl.lim_sel = xyph_pkg::LIM_PITCH;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            ctrl.pitch_en = 1'b1;
            state_in      = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (valid_ff && rsp_ready) valid_in = 1'b0;
      if (state_ff == ST_OUT)    valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

FILE: rtl/xy_position_hold_controller.sv
// XY position hold controller: cascaded position/speed loops on one shared
// 32x16 multiplier with a 49-bit accumulator, stepped by a one-hot sequencer.
// A new item is accepted only in the idle state, once the sequencer has stepped
// through all eleven sequencer steps of the last one; the sequencer also holds
// while a finished result is still waiting to be taken.
// Reset: synchronous, active high; loads default gains/limits, clears the
// previous X error and the handshake state.
module xy_position_hold_controller #(
   parameter int DATA_FRAC_BITS = xyph_pkg::DATA_FRAC_BITS_DEF,
   parameter int GAIN_FRAC_BITS = xyph_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   xyph_req_if.sink                        req_if,
   xyph_rsp_if.source                      rsp_if,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [xyph_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [xyph_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [xyph_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   xyph_pkg::cfg_type  cfg;
   xyph_pkg::ctrl_type ctrl;
   logic               req_ready;
   logic               rsp_valid;

   xyph_csr #(
      .DATA_FRAC_BITS (DATA_FRAC_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   xyph_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_if.ready),
      .ctrl      (ctrl)
   );

   xyph_alu #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_alu (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .cfg       (cfg),
      .pos_x     (req_if.pos_x),
      .pos_y     (req_if.pos_y),
      .speed_x   (req_if.speed_x),
      .speed_y   (req_if.speed_y),
      .roll_cmd  (rsp_if.roll_cmd),
      .pitch_cmd (rsp_if.pitch_cmd)
   );

   assign req_if.ready = req_ready;
   assign rsp_if.valid = rsp_valid;

endmodule
